FILE: hw/rtl/lhp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhp_pkg: shared types and constants of the latency histogram
// Item field widths, action and result-select codes, divider sizing and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lhp_pkg;

  // Item field widths
  localparam int ACT_W   = 2;
  localparam int TS_W    = 64;
  localparam int PCT_W   = 7;
  localparam int VALUE_W = 55;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Percent handling: clamp and half-up rounding term
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam int ROUND_HALF = 50;

  // Divisors of the elapsed time and of the scaled total
  localparam logic [9:0] DVS_US  = 10'd1000;
  localparam logic [9:0] DVS_PCT = 10'd100;

  // Shared constant divider: dividend width, digit width and count, and the
  // power-of-two and odd factors of each divisor (1000 = 8 * 125, 100 = 4 * 25)
  localparam int DIV_W      = 72;
  localparam int DIG_W      = 18;
  localparam int DIV_DIGITS = DIV_W / DIG_W;
  localparam int DIV_CNT_W  = $clog2(2 * DIV_DIGITS + 1);
  localparam int REM_W      = 7;
  localparam int SH_US      = 3;
  localparam int SH_PCT     = 2;
  localparam logic [REM_W-1:0] ODD_US  = 7'd125;
  localparam logic [REM_W-1:0] ODD_PCT = 7'd25;

  // Reciprocals: ceil(2^RECIP_K / odd factor), exact for every partial dividend
  localparam int RECIP_K = 32;
  localparam int RECIP_W = 28;
  localparam logic [RECIP_W-1:0] RECIP_US  = 28'd34359739;
  localparam logic [RECIP_W-1:0] RECIP_PCT = 28'd171798692;

  // Result select codes
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_US   = 2'd1;
  localparam logic [1:0] RES_WALK = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       sweep_wr;
    logic       div_start;
    logic       div_pct;
    logic       cap_prod;
    logic       cap_us;
    logic       cap_target;
    logic       min_upd;
    logic       rd_en;
    logic       rd_walk;
    logic       bin_inc;
    logic       walk_step;
    logic       load_out;
    logic [1:0] res_sel;
  } lhp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             neg;
    logic             no_sample;
    logic             div_done;
    logic             us_in_range;
    logic             walk_go;
    logic             sweep_last;
    logic             out_free;
  } lhp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lhp_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhp_req_if: request channel
// Valid/ready channel carrying one add, query or clear item.
// ----------------------------------------------------------------------------
interface lhp_req_if import lhp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [TS_W-1:0]  start_ns;
  logic [TS_W-1:0]  end_ns;
  logic [PCT_W-1:0] percent;

  modport source (output valid, output action, output start_ns, output end_ns,
                  output percent, input ready);
  modport sink (input valid, input action, input start_ns, input end_ns,
                input percent, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lhp_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhp_rsp_if: response channel
// Valid/ready channel carrying one result value per request item.
// ----------------------------------------------------------------------------
interface lhp_rsp_if import lhp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lhp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lhp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lhp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhp_div: multi-cycle divider by a constant
// Drops the power-of-two factor with a shift, then runs long division by the
// odd factor in DIG_W-bit digits: for each digit a reciprocal multiply first
// estimates the digit, then the remainder is formed and the digit shifted in.
// ----------------------------------------------------------------------------
module lhp_div import lhp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             pct,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int PART_W = REM_W + DIG_W;
  localparam int PROD_W = PART_W + RECIP_W;

  logic [DIV_CNT_W-1:0] cnt;
  logic                 pct_r;
  logic [DIV_W-1:0]     quo_r;
  logic [REM_W-1:0]     rem_r;
  logic [DIG_W-1:0]     qd_r;
  logic [PART_W-1:0]    part_w;
  logic [RECIP_W-1:0]   recip_w;
  logic [REM_W-1:0]     odd_w;
  logic [PROD_W-1:0]    prod_w;
  logic [PART_W-1:0]    back_w;
  logic [PART_W-1:0]    rem_w;

  // Partial dividend: remainder so far with the next digit of the dividend
  assign part_w  = {rem_r, quo_r[DIV_W-1 -: DIG_W]};
  assign recip_w = pct_r ? RECIP_PCT : RECIP_US;
  assign odd_w   = pct_r ? ODD_PCT : ODD_US;

  // Digit estimate from the reciprocal, remainder from the held digit
  assign prod_w = part_w * recip_w;
  assign back_w = qd_r * odd_w;
  assign rem_w  = part_w - back_w;

  // Load on start, then step through the digits until the count runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= DIV_CNT_W'(2 * DIV_DIGITS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - DIV_CNT_W'(1);
      done <= (cnt == DIV_CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Even count: hold the digit; odd count: keep the remainder, shift digit in
  always_ff @(posedge clk) begin
    if (start) begin
      pct_r <= pct;
      quo_r <= pct ? (dividend >> SH_PCT) : (dividend >> SH_US);
      rem_r <= '0;
    end else if (cnt != '0) begin
      if (!cnt[0]) begin
        qd_r <= prod_w[RECIP_K +: DIG_W];
      end else begin
        rem_r <= rem_w[REM_W-1:0];
        quo_r <= {quo_r[DIV_W-DIG_W-1:0], qd_r};
      end
    end
  end

  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: hw/rtl/lhp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhp_datapath: histogram storage and arithmetic
// Bin RAM, total and minimum registers, elapsed-time and target division,
// percentile walk accumulator and the output register.
// ----------------------------------------------------------------------------
module lhp_datapath import lhp_pkg::*; #(
  parameter int NUM_BINS    = 8192,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  lhp_cmd_t           cmd,
  output lhp_sts_t           sts,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [TS_W-1:0]    in_start_ns,
  input  logic [TS_W-1:0]    in_end_ns,
  input  logic [PCT_W-1:0]   in_percent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_value
);

  localparam int ADDR_W = $clog2(NUM_BINS);
  localparam int IDX_W  = $clog2(NUM_BINS + 2);
  localparam int SUM_W  = COUNT_WIDTH + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // Latched item
  logic [ACT_W-1:0] act_r;
  logic [TS_W-1:0]  diff_r;
  logic             neg_r;
  logic [PCT_W-1:0] pct_r;

  // Histogram state
  logic [COUNT_WIDTH-1:0] total_r;
  logic [IDX_W-1:0]       min_r;
  logic [ADDR_W-1:0]      sweep_r;

  // Work registers
  logic [DIV_W-1:0]       prod_r;
  logic [VALUE_W-1:0]     us_r;
  logic [COUNT_WIDTH-1:0] target_r;
  logic [IDX_W-1:0]       idx_r;
  logic [SUM_W-1:0]       sum_r;

  logic [COUNT_WIDTH+PCT_W-1:0] mul_w;
  logic [DIV_W-1:0]             quotient;
  logic                         div_done;
  logic [COUNT_WIDTH-1:0]       rdata;
  logic [COUNT_WIDTH-1:0]       bin_inc_w;
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [COUNT_WIDTH-1:0]       ram_wdata;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [IDX_W-1:0]             idx_m1;
  logic [VALUE_W-1:0]           res_w;

  // Latch the item: elapsed time, underflow flag and clamped percent
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r  <= in_action;
      diff_r <= in_end_ns - in_start_ns;
      neg_r  <= (in_end_ns < in_start_ns);
      pct_r  <= (in_percent > PCT_MAX) ? PCT_MAX : in_percent;
    end
  end

  // Scaled total plus rounding term, divided by 100 later
  assign mul_w = total_r * pct_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_prod) begin
      prod_r <= DIV_W'(mul_w) + DIV_W'(ROUND_HALF);
    end
  end

  lhp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .pct      (cmd.div_pct),
    .dividend (cmd.div_pct ? prod_r : DIV_W'(diff_r)),
    .done     (div_done),
    .quotient (quotient)
  );

  // Bin memory: sweep writes zero, add writes the saturated increment
  assign bin_inc_w = (rdata == CNT_MAX) ? rdata : rdata + COUNT_WIDTH'(1);
  assign ram_we    = cmd.sweep_wr | cmd.bin_inc;
  assign ram_waddr = cmd.sweep_wr ? sweep_r : us_r[ADDR_W-1:0];
  assign ram_wdata = cmd.sweep_wr ? '0 : bin_inc_w;
  assign ram_raddr = cmd.rd_walk ? idx_r[ADDR_W-1:0] : us_r[ADDR_W-1:0];

  lhp_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Sweep pointer wraps back to zero after the last bin
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_r <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_r <= sts.sweep_last ? '0 : sweep_r + ADDR_W'(1);
    end
  end

  // Total and minimum: cleared by the sweep, bumped by an add
  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      total_r <= '0;
      min_r   <= IDX_W'(NUM_BINS + 1);
    end else begin
      if (cmd.bin_inc && (total_r != CNT_MAX)) begin
        total_r <= total_r + COUNT_WIDTH'(1);
      end
      if (cmd.min_upd && (us_r < VALUE_W'(min_r))) begin
        min_r <= us_r[IDX_W-1:0];
      end
    end
  end

  // Capture quotients and run the walk
  always_ff @(posedge clk) begin
    if (cmd.cap_us) begin
      us_r <= quotient[VALUE_W-1:0];
    end
    if (cmd.cap_target) begin
      target_r <= quotient[COUNT_WIDTH-1:0];
      idx_r    <= min_r;
      sum_r    <= '0;
    end else if (cmd.walk_step) begin
      idx_r <= idx_r + IDX_W'(1);
      sum_r <= sum_r + SUM_W'(rdata);
    end
  end

  // Select and hold the result until taken
  assign idx_m1 = idx_r - IDX_W'(1);

  always_comb begin
    case (cmd.res_sel)
      RES_US:   res_w = us_r;
      RES_WALK: res_w = (idx_r == '0) ? '0 : VALUE_W'(idx_m1);
      default:  res_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value <= res_w;
    end
  end

  // Status back to the controller
  assign sts.action      = act_r;
  assign sts.neg         = neg_r;
  assign sts.no_sample   = (min_r > IDX_W'(NUM_BINS));
  assign sts.div_done    = div_done;
  assign sts.us_in_range = (us_r < VALUE_W'(NUM_BINS));
  assign sts.walk_go     = (sum_r < {1'b0, target_r}) && (idx_r < IDX_W'(NUM_BINS));
  assign sts.sweep_last  = (sweep_r == ADDR_W'(NUM_BINS - 1));
  assign sts.out_free    = !out_valid || out_ready;

endmodule
`default_nettype wire

FILE: hw/rtl/lhp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhp_ctrl: sequencing state machine
// Runs the clear sweep, add read-modify-write, percentile walk and result
// handoff by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module lhp_ctrl import lhp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  lhp_sts_t sts,
  output lhp_cmd_t cmd
);

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DISPATCH = 4'd2;
  localparam logic [3:0] ST_QSTART   = 4'd3;
  localparam logic [3:0] ST_DIV      = 4'd4;
  localparam logic [3:0] ST_ADD_UPD  = 4'd5;
  localparam logic [3:0] ST_ADD_WR   = 4'd6;
  localparam logic [3:0] ST_WALK_CHK = 4'd7;
  localparam logic [3:0] ST_WALK_ACC = 4'd8;
  localparam logic [3:0] ST_RESULT   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] res;
  logic [1:0] res_next;
  logic       clr_item;
  logic       clr_item_next;

  assign req_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    res_next      = res;
    clr_item_next = clr_item;
    cmd           = '0;
    cmd.res_sel   = res;
    cmd.load_item = req_valid && req_ready;
    case (state)
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          clr_item_next = 1'b0;
          res_next      = RES_ZERO;
          state_next    = clr_item ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.action)
          ACT_ADD: begin
            if (sts.neg) begin
              res_next   = RES_ZERO;
              state_next = ST_RESULT;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = ST_DIV;
            end
          end
          ACT_QUERY: begin
            if (sts.no_sample) begin
              res_next   = RES_ZERO;
              state_next = ST_RESULT;
            end else begin
              cmd.cap_prod = 1'b1;
              state_next   = ST_QSTART;
            end
          end
          ACT_CLEAR: begin
            clr_item_next = 1'b1;
            state_next    = ST_CLEAR;
          end
          default: begin
            res_next   = RES_ZERO;
            state_next = ST_RESULT;
          end
        endcase
      end
      ST_QSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_pct   = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          if (sts.action == ACT_ADD) begin
            cmd.cap_us = 1'b1;
            state_next = ST_ADD_UPD;
          end else begin
            cmd.cap_target = 1'b1;
            state_next     = ST_WALK_CHK;
          end
        end
      end
      ST_ADD_UPD: begin
        cmd.min_upd = 1'b1;
        if (sts.us_in_range) begin
          cmd.rd_en  = 1'b1;
          state_next = ST_ADD_WR;
        end else begin
          res_next   = RES_US;
          state_next = ST_RESULT;
        end
      end
      ST_ADD_WR: begin
        cmd.bin_inc = 1'b1;
        res_next    = RES_US;
        state_next  = ST_RESULT;
      end
      ST_WALK_CHK: begin
        if (sts.walk_go) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_walk = 1'b1;
          state_next  = ST_WALK_ACC;
        end else begin
          res_next   = RES_WALK;
          state_next = ST_RESULT;
        end
      end
      ST_WALK_ACC: begin
        cmd.walk_step = 1'b1;
        state_next    = ST_WALK_CHK;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      res      <= RES_ZERO;
      clr_item <= 1'b0;
    end else begin
      state    <= state_next;
      res      <= res_next;
      clr_item <= clr_item_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/latency_histogram_percentile.sv
`default_nettype none
// ----------------------------------------------------------------------------
// latency_histogram_percentile: microsecond latency histogram with percentiles
// Adds elapsed-time samples to per-microsecond bins, answers whole-percent
// percentile queries by walking the bins, and clears on request.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                              handshake
//  req      in         action, start_ns, end_ns, percent    valid/ready
//  rsp      out        value (one per req item)             valid/ready
//
//  Add: divides by 1000 (four 18-bit digits); a sample beyond the last bin
//  skips the bin read and write. Query: walks the bins through the one bin
//  RAM read port (registered read). Clear: sweeps one bin per cycle.
//  Dropped sample, unused action or query with no sample: straight to result.
//  After reset the same sweep runs before req.ready rises.
//  One item is in work at a time; the result register holds under rsp stall.
// ----------------------------------------------------------------------------
module latency_histogram_percentile import lhp_pkg::*; #(
  parameter int NUM_BINS    = 8192,
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  lhp_req_if.sink   req,
  lhp_rsp_if.source rsp
);

  lhp_cmd_t cmd;
  lhp_sts_t sts;

  lhp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lhp_datapath #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_action   (req.action),
    .in_start_ns (req.start_ns),
    .in_end_ns   (req.end_ns),
    .in_percent  (req.percent),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_value   (rsp.value)
  );

`ifndef NO_ASSERTIONS
  // No item is taken while the bins are being cleared
  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_wr |-> !req.ready)
    else $error("item accepted during clear sweep");

  // A new result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp.valid || rsp.ready))
    else $error("result overwritten before taken");

  // The bin write of an add follows its read of the same bin
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    cmd.bin_inc |-> $past(cmd.rd_en && !cmd.rd_walk))
    else $error("bin increment without preceding read");

  // One item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item accepted while one is in work");

  // The divider never finishes right after starting
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done too early");
`endif

endmodule
`default_nettype wire
